// ===== design/stt_pkg.sv =====
// Shared types and character constants for the shell command tokenizer.
package stt_pkg;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_OK   = 2'd2,
        KIND_ERR  = 2'd3
    } t_kind;

    // Parser modes, one-hot.
    typedef enum logic [6:0] {
        MODE_BETWEEN   = 7'b0000001,
        MODE_WORD      = 7'b0000010,
        MODE_SQ        = 7'b0000100,
        MODE_SQ_CLOSED = 7'b0001000,
        MODE_SQ_BS     = 7'b0010000,
        MODE_SQ_BSQ    = 7'b0100000,
        MODE_DQ        = 7'b1000000
    } t_mode;

    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_BSL = 8'h5C;

    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    // All results caused by one input item; cnt is 1 to 3 when queued.
    typedef struct packed {
        logic [1:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_bundle;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== design/stt_front.sv =====
// Front part: accepts input items, runs the quote parser and builds result bundles.
module stt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    input  logic [7:0]       i_ch,
    input  stt_pkg::t_q_stat i_q_stat,
    output logic             o_ready,
    output logic             o_push,
    output stt_pkg::t_bundle o_bundle
);

    stt_pkg::t_mode   r_mode;
    stt_pkg::t_mode   n_mode;
    logic             r_bsodd;
    logic             n_bsodd;
    logic             accept;
    logic             do_bare;
    logic             in_tok;
    stt_pkg::t_bundle bundle;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Appends one result to a bundle; a non-byte kind carries a zero byte.
    function automatic stt_pkg::t_bundle put(input stt_pkg::t_bundle b,
                                             input stt_pkg::t_kind k,
                                             input logic [7:0] v);
        stt_pkg::t_bundle r;
        r = b;
        r.res[r.cnt].kind = k;
        r.res[r.cnt].data = (k == stt_pkg::KIND_BYTE) ? v : 8'd0;
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        bundle  = '0;
        n_mode  = r_mode;
        n_bsodd = r_bsodd;
        do_bare = 1'b0;
        in_tok  = 1'b1;
        if (i_action) begin
            unique case (r_mode) inside
                stt_pkg::MODE_WORD, stt_pkg::MODE_SQ_CLOSED: begin
                    bundle = put(bundle, stt_pkg::KIND_END, 8'd0);
                    bundle = put(bundle, stt_pkg::KIND_OK, 8'd0);
                end
                stt_pkg::MODE_SQ_BS: begin
                    bundle = put(bundle, stt_pkg::KIND_BYTE, stt_pkg::CH_BSL);
                    bundle = put(bundle, stt_pkg::KIND_END, 8'd0);
                    bundle = put(bundle, stt_pkg::KIND_OK, 8'd0);
                end
                stt_pkg::MODE_SQ_BSQ: begin
                    bundle = put(bundle, stt_pkg::KIND_BYTE, stt_pkg::CH_BSL);
                    bundle = put(bundle, stt_pkg::KIND_ERR, 8'd0);
                end
                stt_pkg::MODE_SQ, stt_pkg::MODE_DQ: begin
                    bundle = put(bundle, stt_pkg::KIND_ERR, 8'd0);
                end
                default: begin
                    bundle = put(bundle, stt_pkg::KIND_OK, 8'd0);
                end
            endcase
            n_mode  = stt_pkg::MODE_BETWEEN;
            n_bsodd = 1'b0;
        end else begin
            unique case (r_mode)
                stt_pkg::MODE_WORD: begin
                    do_bare = 1'b1;
                end
                stt_pkg::MODE_SQ: begin
                    if (i_ch == stt_pkg::CH_SQ) begin
                        n_mode = stt_pkg::MODE_SQ_CLOSED;
                    end else begin
                        bundle = put(bundle, stt_pkg::KIND_BYTE, i_ch);
                    end
                end
                stt_pkg::MODE_SQ_CLOSED: begin
                    if (i_ch == stt_pkg::CH_BSL) begin
                        n_mode = stt_pkg::MODE_SQ_BS;
                    end else begin
                        do_bare = 1'b1;
                    end
                end
                stt_pkg::MODE_SQ_BS: begin
                    if (i_ch == stt_pkg::CH_SQ) begin
                        n_mode = stt_pkg::MODE_SQ_BSQ;
                    end else begin
                        bundle  = put(bundle, stt_pkg::KIND_BYTE, stt_pkg::CH_BSL);
                        do_bare = 1'b1;
                    end
                end
                stt_pkg::MODE_SQ_BSQ: begin
                    if (i_ch == stt_pkg::CH_SQ) begin
                        bundle = put(bundle, stt_pkg::KIND_BYTE, stt_pkg::CH_SQ);
                    end else begin
                        bundle = put(bundle, stt_pkg::KIND_BYTE, stt_pkg::CH_BSL);
                        bundle = put(bundle, stt_pkg::KIND_BYTE, i_ch);
                    end
                    n_mode = stt_pkg::MODE_SQ;
                end
                stt_pkg::MODE_DQ: begin
                    if ((i_ch == stt_pkg::CH_DQ) && !r_bsodd) begin
                        n_mode  = stt_pkg::MODE_WORD;
                        n_bsodd = 1'b0;
                    end else begin
                        bundle  = put(bundle, stt_pkg::KIND_BYTE, i_ch);
                        n_bsodd = (i_ch == stt_pkg::CH_BSL) ? !r_bsodd : 1'b0;
                    end
                end
                default: begin
                    do_bare = 1'b1;
                    in_tok  = 1'b0;
                end
            endcase
        end

        // Handling of a byte that stands outside any quote.
        if (do_bare) begin
            if (is_ws(i_ch)) begin
                if (in_tok) begin
                    bundle = put(bundle, stt_pkg::KIND_END, 8'd0);
                end
                n_mode = stt_pkg::MODE_BETWEEN;
            end else if (i_ch == stt_pkg::CH_SQ) begin
                n_mode = stt_pkg::MODE_SQ;
            end else if (i_ch == stt_pkg::CH_DQ) begin
                n_mode  = stt_pkg::MODE_DQ;
                n_bsodd = 1'b0;
            end else begin
                bundle = put(bundle, stt_pkg::KIND_BYTE, i_ch);
                n_mode = stt_pkg::MODE_WORD;
            end
        end
    end

    assign o_push   = accept && (bundle.cnt != 2'd0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= stt_pkg::MODE_BETWEEN;
            r_bsodd <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_bsodd <= n_bsodd;
        end
    end

`ifndef SYNTH
    a_end_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action) |=> (r_mode == stt_pkg::MODE_BETWEEN) && !r_bsodd)
        else $error("end of command did not return the parser to its reset mode");

    a_bsodd_only_in_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bsodd |-> (r_mode == stt_pkg::MODE_DQ))
        else $error("backslash parity set outside a double-quoted section");

    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action) |-> o_push)
        else $error("end of command produced no status result");
`endif

endmodule

// ===== design/stt_fifo.sv =====
// Short queue of result bundles between the parser and the output serializer.
module stt_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_bundle i_wdata,
    input  logic             i_pop,
    output stt_pkg::t_bundle o_rdata,
    output stt_pkg::t_q_stat o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    stt_pkg::t_bundle r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("bundle pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("bundle popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy beyond its depth");
`endif

endmodule

// ===== design/stt_back.sv =====
// Back part: sends the results of the head bundle one transfer at a time.
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stt_pkg::t_q_stat i_q_stat,
    input  stt_pkg::t_bundle i_bundle,
    input  logic             i_m_tready,
    output logic             o_pop,
    output logic             o_m_tvalid,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic [1:0]       o_m_tuser,   // [1:0] kind
    output logic             o_m_tlast
);

    logic [1:0]     r_idx;
    logic           xfer;
    logic           is_last;
    stt_pkg::t_res  cur;

    assign o_m_tvalid = !i_q_stat.empty;
    assign cur        = i_bundle.res[r_idx];
    assign is_last    = (r_idx == (i_bundle.cnt - 2'd1));
    assign xfer       = o_m_tvalid && i_m_tready;
    assign o_pop      = xfer && is_last;
    assign o_m_tdata  = cur.data;
    assign o_m_tuser  = cur.kind;
    assign o_m_tlast  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (xfer) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

`ifndef SYNTH
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_idx < i_bundle.cnt))
        else $error("result index points past the head bundle");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> (r_idx == 2'd0))
        else $error("result index not at start while the queue is empty");

    a_idx_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !is_last) |=> (r_idx == $past(r_idx) + 2'd1))
        else $error("result index did not advance after a middle transfer");
`endif

endmodule

// ===== design/shell_command_tokenizer_top.sv =====
// Top level of the shell command tokenizer: parser, bundle queue and output serializer.
// Results of an accepted item are registered in the queue and reach the master side from its head.
// Throughput: one item per cycle while each item causes at most one result and i_m_tready
// is high; an item that causes k results holds the output for k transfers, and the queue of
// QUEUE_DEPTH bundles absorbs such bursts before the slave side stalls.
// Reset: synchronous and active low; it empties the queue and returns the parser to between tokens.
module shell_command_tokenizer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream: one command byte or an end-of-command marker per transfer.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_s_tuser,   // [0] action (1 marks end of command)
    // Output stream: one result per transfer.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte (zero unless kind is a token byte)
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last result caused by one input item
);

    // The front part classifies each accepted byte and produces a bundle holding every
    // result it causes. Items that cause no result, such as whitespace between tokens or
    // an opening quote, leave the queue untouched.
    stt_pkg::t_q_stat q_stat;
    stt_pkg::t_bundle push_bundle;
    stt_pkg::t_bundle head_bundle;
    logic             push;
    logic             pop;

    stt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_action (i_s_tuser),
        .i_ch     (i_s_tdata),
        .i_q_stat (q_stat),
        .o_ready  (o_s_tready),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // The queue separates the two sides, so the parser keeps taking bytes while an earlier
    // bundle still waits on the output.
    stt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_bundle),
        .i_pop   (pop),
        .o_rdata (head_bundle),
        .o_stat  (q_stat)
    );

    // The back part walks through the head bundle and pops it after its last transfer.
    stt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_bundle   (head_bundle),
        .i_m_tready (i_m_tready),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
